FILE: rtl/core/lsw_pkg.sv
// Shared types and constants for the LED strip wipe sequencer.
// Used by lsw_strip_unit and led_strip_wipe_sequencer_unit; depends on nothing.
package lsw_pkg;

   localparam int STRIP_COUNT = 4;
   localparam int MAX_LEDS    = 1024;

   localparam int STRIP_W  = 2;
   localparam int MASK_W   = 4;
   localparam int CNT_W    = 11;
   localparam int LED_W    = 10;
   localparam int COLOR_W  = 24;
   localparam int TIME_W   = 32;
   localparam int IVAL_W   = 16;
   localparam int ACT_W    = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;

   typedef logic [STRIP_W-1:0]    strip_type;
   typedef logic [CNT_W-1:0]      count_type;
   typedef logic [LED_W-1:0]      led_type;
   typedef logic [COLOR_W-1:0]    color_type;
   typedef logic [TIME_W-1:0]     time_type;
   typedef logic [ACT_W-1:0]      action_type;
   typedef logic [1:0]            command_type;
   typedef logic [1:0]            phase_type;
   typedef logic [CSR_IDX_W-1:0]  csr_index_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   localparam action_type ACT_TICK         = 3'd0;
   localparam action_type ACT_BEGIN        = 3'd1;
   localparam action_type ACT_START_OPEN   = 3'd2;
   localparam action_type ACT_START_CLOSE  = 3'd3;
   localparam action_type ACT_COLOR_CHANGE = 3'd4;

   localparam command_type CMD_SET_PIXEL = 2'd0;
   localparam command_type CMD_FILL      = 2'd1;
   localparam command_type CMD_CLEAR     = 2'd2;

   localparam phase_type PH_OFF  = 2'd0;
   localparam phase_type PH_ON   = 2'd1;
   localparam phase_type PH_UP   = 2'd2;
   localparam phase_type PH_DOWN = 2'd3;

   localparam csr_index_type CSR_ENABLE_MASK = 3'd0;
   localparam csr_index_type CSR_COUNT_A     = 3'd1;
   localparam csr_index_type CSR_COUNT_B     = 3'd2;
   localparam csr_index_type CSR_COUNT_C     = 3'd3;
   localparam csr_index_type CSR_COUNT_D     = 3'd4;
   localparam csr_index_type CSR_INTERVAL    = 3'd5;
   localparam csr_index_type CSR_POWER       = 3'd6;
   localparam csr_index_type CSR_COLOR       = 3'd7;

   typedef struct packed {
      logic      active;
      count_type count;
      logic      open_hit;
      led_type   open_led;
      logic      close_hit;
      led_type   close_led;
   } strip_eval_type;

endpackage

FILE: rtl/core/led_strip_wipe_sequencer_unit.sv
// Top level of the LED strip wipe sequencer: register file, step sequencer and
// result register. Depends on lsw_pkg and lsw_strip_unit.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | action, now_ms, target_color
//   rsp     | out       | rsp_valid/rsp_ready  | command, strip_index, led_index,
//           |           |                      | pixel_color, phase, last
//   csr     | in        | csr_valid/csr_ready  | index, data
//
// An unknown action, a tick outside an animation or inside the step interval, and an
// opening tick that finds the wipe complete are handled in the idle state without leaving
// it. Every other item is accepted in the idle state, then the strip unit visits the
// strips one per cycle, the decide state settles the new state, and the emit state then
// issues each result beat. Stalls on rsp hold the sequencer. The result register lets
// the next request be taken while the final beat waits. Reset is synchronous and active
// high; there is no clearing pass.
module led_strip_wipe_sequencer_unit (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  lsw_pkg::action_type    req_action,
   input  lsw_pkg::time_type      req_now_ms,
   input  lsw_pkg::color_type     req_target_color,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lsw_pkg::command_type   rsp_command,
   output lsw_pkg::strip_type     rsp_strip_index,
   output lsw_pkg::led_type       rsp_led_index,
   output lsw_pkg::color_type     rsp_pixel_color,
   output lsw_pkg::phase_type     rsp_phase,
   output logic                   rsp_last,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  lsw_pkg::csr_index_type csr_index,
   input  lsw_pkg::csr_data_type  csr_data
);
   import lsw_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DECIDE, ST_EMIT} state_type;
   typedef enum logic [1:0] {MODE_OPEN, MODE_CLOSE, MODE_FIND} mode_type;

   state_type               state_ff;
   mode_type                mode_ff;

   logic [MASK_W-1:0]       enable_mask_ff;
   count_type               led_count_ff [MASK_W];
   logic [IVAL_W-1:0]       interval_ff;
   logic                    power_at_begin_ff;
   color_type               color_at_begin_ff;

   phase_type               phase_ff;
   count_type               step_count_ff;
   time_type                last_step_time_ff;
   count_type               longest_ff;
   color_type               current_color_ff;
   color_type               pending_color_ff;
   logic                    change_pending_ff;
   logic                    power_ff;

   action_type              action_ff;
   color_type               target_ff;
   strip_type               cursor_ff;
   count_type               longest_acc_ff;
   logic [STRIP_COUNT-1:0]  hit_ff;
   led_type                 led_ff [STRIP_COUNT];

   logic                    lead_ff;
   logic                    trail_ff;
   command_type             kind_ff;
   color_type               color_ff;

   logic                    rsp_valid_ff;
   command_type             rsp_command_ff;
   strip_type               rsp_strip_ff;
   led_type                 rsp_led_ff;
   color_type               rsp_color_ff;
   phase_type               rsp_phase_ff;
   logic                    rsp_last_ff;

   strip_eval_type          eval;
   time_type                elapsed_in;
   count_type               step_next_in;
   logic                    slot_free;
   strip_type               pick_in;
   logic [STRIP_COUNT-1:0]  rest_in;

   lsw_strip_unit u_strip (
      .enable    (enable_mask_ff[cursor_ff]),
      .count_raw (led_count_ff[cursor_ff]),
      .step      (step_count_ff),
      .longest   (longest_ff),
      .eval      (eval)
   );

   assign req_ready    = (state_ff == ST_IDLE);
   assign csr_ready    = 1'b1;
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign elapsed_in   = req_now_ms - last_step_time_ff;
   assign step_next_in = step_count_ff + CNT_W'(1);

   always_comb begin
      pick_in = '0;
      for (int i = STRIP_COUNT - 1; i >= 0; i--) begin
         if (hit_ff[i]) begin
            pick_in = STRIP_W'(i);
         end
      end
      for (int i = 0; i < STRIP_COUNT; i++) begin
         rest_in[i] = hit_ff[i] && (STRIP_W'(i) != pick_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         mode_ff           <= MODE_FIND;
         enable_mask_ff    <= 4'hF;
         for (int i = 0; i < MASK_W; i++) begin
            led_count_ff[i] <= '0;
         end
         interval_ff       <= IVAL_W'(50);
         power_at_begin_ff <= 1'b0;
         color_at_begin_ff <= '0;
         phase_ff          <= PH_OFF;
         step_count_ff     <= '0;
         last_step_time_ff <= '0;
         longest_ff        <= '0;
         current_color_ff  <= '0;
         pending_color_ff  <= '0;
         change_pending_ff <= 1'b0;
         power_ff          <= 1'b0;
         cursor_ff         <= '0;
         lead_ff           <= 1'b0;
         trail_ff          <= 1'b0;
         hit_ff            <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ENABLE_MASK: enable_mask_ff    <= csr_data[MASK_W-1:0];
               CSR_COUNT_A:     led_count_ff[0]   <= csr_data[CNT_W-1:0];
               CSR_COUNT_B:     led_count_ff[1]   <= csr_data[CNT_W-1:0];
               CSR_COUNT_C:     led_count_ff[2]   <= csr_data[CNT_W-1:0];
               CSR_COUNT_D:     led_count_ff[3]   <= csr_data[CNT_W-1:0];
               CSR_INTERVAL:    interval_ff       <= csr_data[IVAL_W-1:0];
               CSR_POWER:       power_at_begin_ff <= csr_data[0];
               CSR_COLOR:       color_at_begin_ff <= csr_data[COLOR_W-1:0];
            endcase
         end

         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  action_ff      <= req_action;
                  target_ff      <= req_target_color;
                  cursor_ff      <= '0;
                  longest_acc_ff <= '0;
                  priority if (req_action == ACT_TICK) begin
                     if ((phase_ff == PH_UP || phase_ff == PH_DOWN) &&
                         (elapsed_in >= TIME_W'(interval_ff))) begin
                        last_step_time_ff <= req_now_ms;
                        if (phase_ff == PH_UP) begin
                           if (step_count_ff >= longest_ff) begin
                              phase_ff          <= PH_ON;
                              change_pending_ff <= 1'b0;
                           end else begin
                              mode_ff  <= MODE_OPEN;
                              state_ff <= ST_SCAN;
                           end
                        end else begin
                           mode_ff  <= MODE_CLOSE;
                           state_ff <= ST_SCAN;
                        end
                     end
                  end else if (req_action == ACT_BEGIN || req_action == ACT_START_OPEN ||
                               req_action == ACT_START_CLOSE ||
                               req_action == ACT_COLOR_CHANGE) begin
                     mode_ff  <= MODE_FIND;
                     state_ff <= ST_SCAN;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end

            ST_SCAN: begin
               unique case (mode_ff)
                  MODE_OPEN: begin
                     hit_ff[cursor_ff] <= eval.open_hit;
                     led_ff[cursor_ff] <= eval.open_led;
                  end
                  MODE_CLOSE: begin
                     hit_ff[cursor_ff] <= eval.close_hit;
                     led_ff[cursor_ff] <= eval.close_led;
                  end
                  default: begin
                     hit_ff[cursor_ff] <= eval.active;
                     led_ff[cursor_ff] <= '0;
                  end
               endcase
               if (eval.active && (eval.count > longest_acc_ff)) begin
                  longest_acc_ff <= eval.count;
               end
               if (cursor_ff == STRIP_W'(STRIP_COUNT - 1)) begin
                  state_ff <= ST_DECIDE;
               end else begin
                  cursor_ff <= cursor_ff + STRIP_W'(1);
               end
            end

            ST_DECIDE: begin
               lead_ff  <= 1'b0;
               trail_ff <= 1'b0;
               kind_ff  <= CMD_SET_PIXEL;
               color_ff <= '0;
               state_ff <= ST_IDLE;
               unique case (mode_ff)
                  MODE_OPEN: begin
                     step_count_ff <= step_next_in;
                     color_ff      <= current_color_ff;
                     if (hit_ff != '0) begin
                        state_ff <= ST_EMIT;
                     end
                  end
                  MODE_CLOSE: begin
                     state_ff <= ST_EMIT;
                     if ((hit_ff == '0) || (step_next_in > longest_ff)) begin
                        trail_ff <= 1'b1;
                        if (change_pending_ff) begin
                           current_color_ff  <= pending_color_ff;
                           power_ff          <= 1'b1;
                           step_count_ff     <= '0;
                           last_step_time_ff <= '0;
                           phase_ff          <= PH_UP;
                        end else begin
                           step_count_ff <= step_next_in;
                           power_ff      <= 1'b0;
                           phase_ff      <= PH_OFF;
                        end
                     end else begin
                        step_count_ff <= step_next_in;
                     end
                  end
                  default: begin
                     longest_ff <= longest_acc_ff;
                     priority if (action_ff == ACT_BEGIN) begin
                        power_ff         <= power_at_begin_ff;
                        current_color_ff <= color_at_begin_ff;
                        phase_ff         <= power_at_begin_ff ? PH_ON : PH_OFF;
                        lead_ff          <= 1'b1;
                        kind_ff          <= CMD_FILL;
                        color_ff         <= color_at_begin_ff;
                        if (!power_at_begin_ff) begin
                           hit_ff <= '0;
                        end
                        state_ff <= ST_EMIT;
                     end else if (longest_acc_ff == '0) begin
                        if (action_ff == ACT_COLOR_CHANGE) begin
                           current_color_ff <= target_ff;
                        end
                     end else begin
                        step_count_ff     <= '0;
                        last_step_time_ff <= '0;
                        priority if (action_ff == ACT_START_OPEN) begin
                           change_pending_ff <= 1'b0;
                           power_ff          <= 1'b1;
                           phase_ff          <= PH_UP;
                           lead_ff           <= 1'b1;
                           hit_ff            <= '0;
                           state_ff          <= ST_EMIT;
                        end else if (action_ff == ACT_START_CLOSE) begin
                           change_pending_ff <= 1'b0;
                           power_ff          <= 1'b0;
                           phase_ff          <= PH_DOWN;
                        end else begin
                           pending_color_ff  <= target_ff;
                           change_pending_ff <= 1'b1;
                           phase_ff          <= PH_DOWN;
                        end
                     end
                  end
               endcase
            end

            ST_EMIT: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_phase_ff <= phase_ff;
                  priority if (lead_ff) begin
                     rsp_command_ff <= CMD_CLEAR;
                     rsp_strip_ff   <= '0;
                     rsp_led_ff     <= '0;
                     rsp_color_ff   <= '0;
                     rsp_last_ff    <= (hit_ff == '0) && !trail_ff;
                     lead_ff        <= 1'b0;
                     if ((hit_ff == '0) && !trail_ff) begin
                        state_ff <= ST_IDLE;
                     end
                  end else if (hit_ff != '0) begin
                     rsp_command_ff <= kind_ff;
                     rsp_strip_ff   <= pick_in;
                     rsp_led_ff     <= led_ff[pick_in];
                     rsp_color_ff   <= color_ff;
                     rsp_last_ff    <= (rest_in == '0) && !trail_ff;
                     hit_ff         <= rest_in;
                     if ((rest_in == '0) && !trail_ff) begin
                        state_ff <= ST_IDLE;
                     end
                  end else begin
                     rsp_command_ff <= CMD_CLEAR;
                     rsp_strip_ff   <= '0;
                     rsp_led_ff     <= '0;
                     rsp_color_ff   <= '0;
                     rsp_last_ff    <= 1'b1;
                     trail_ff       <= 1'b0;
                     state_ff       <= ST_IDLE;
                  end
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_command     = rsp_command_ff;
   assign rsp_strip_index = rsp_strip_ff;
   assign rsp_led_index   = rsp_led_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_phase       = rsp_phase_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

FILE: rtl/core/lsw_strip_unit.sv
// Shared per-strip evaluation unit: saturates a strip's LED count and works out
// the opening and closing pixel for the current step. Depends on lsw_pkg.
module lsw_strip_unit (
   input  logic                    enable,
   input  lsw_pkg::count_type      count_raw,
   input  lsw_pkg::count_type      step,
   input  lsw_pkg::count_type      longest,
   output lsw_pkg::strip_eval_type eval
);
   import lsw_pkg::*;

   count_type          cnt;
   logic [CNT_W+1:0]   pos;
   logic               pos_neg;
   count_type          close_diff;

   always_comb begin
      cnt        = (count_raw > CNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : count_raw;
      pos        = {2'b00, step} + {2'b00, cnt} - {2'b00, longest};
      pos_neg    = pos[CNT_W+1];
      close_diff = cnt - CNT_W'(1) - step;

      eval.active    = enable && (cnt != '0);
      eval.count     = cnt;
      eval.open_hit  = eval.active && !pos_neg && (pos[CNT_W:0] < {1'b0, cnt});
      eval.open_led  = pos[LED_W-1:0];
      eval.close_hit = eval.active && (step < cnt);
      eval.close_led = close_diff[LED_W-1:0];
   end

endmodule
